FILE: src/psl_pkg.sv
// Shared types and constants for the pending send latency table.
package psl_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int ENTRY_W = ID_W + TIME_W;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SEND = 2'd1,
    FUNC_ACK  = 2'd2
  } func_t;

  typedef struct packed {
    logic tick;      // advance the millisecond counter
    logic send;      // write entry at the ring cursor
    logic start;     // latch id, issue read of entry zero
    logic step;      // compare one entry, issue next read
    logic capture;   // latch the search result
    logic load_out;  // move result to the output register
  } psl_cmd_t;

  typedef struct packed {
    logic hit;       // entry under compare matches
    logic last;      // entry under compare is the final one
    logic out_free;  // output register can take a result
  } psl_sts_t;

endpackage

FILE: src/pending_send_latency_table.sv
// Top level of the pending send latency table.
// Tick and send transactions leave the input open; a new transaction is taken the next cycle.
// An acknowledge latches the id, then compares the entries one at a time in index order until
// the first match or the final entry, captures the result and loads the output register once
// it is free; the input reopens after that load and is held while the output register is full.
// Synchronous active-low reset clears timer, cursor, pending bits, output valid and controller state only.
module pending_send_latency_table import psl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [ID_W-1:0]   in_packet_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [TIME_W-1:0] out_latency
);

  psl_cmd_t cmd;
  psl_sts_t sts;

  psl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd)
  );

  psl_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_packet_id(in_packet_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_found   (out_found),
    .out_latency (out_latency)
  );

  // a miss always reports zero latency
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_latency == '0)
    else $error("miss result with nonzero latency");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten");

  // an accepted acknowledge blocks the input for the search
  a_ack_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_ACK) |=> !in_ready)
    else $error("input taken during acknowledge search");

  // the search ends only on a match or at the final entry
  a_capture_cause: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> cmd.step && (sts.hit || sts.last))
    else $error("search ended early");

endmodule

FILE: src/psl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/psl_datapath.sv
// Datapath: timer, ring cursor, pending bits, entry RAM, compare and result registers.
module psl_datapath import psl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IDXW = $clog2(TABLE_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psl_cmd_t          cmd,
  output psl_sts_t          sts,
  input  logic [ID_W-1:0]   in_packet_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [TIME_W-1:0] out_latency
);

  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_ENTRIES - 1);

  logic [TIME_W-1:0]        time_now_r;
  logic [IDXW-1:0]          slot_r;
  logic [TABLE_ENTRIES-1:0] pending_r;
  logic [ID_W-1:0]          id_r;
  logic [IDXW-1:0]          rd_idx_r;
  logic [IDXW-1:0]          cmp_idx_r;
  logic                     res_found_r;
  logic [TIME_W-1:0]        res_lat_r;
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [TIME_W-1:0]        out_lat_r;

  logic [IDXW-1:0]    raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_sent;
  logic [TIME_W-1:0]  lat_diff;

  assign raddr   = cmd.step ? rd_idx_r : '0;
  assign rd_id   = rdata[ENTRY_W-1:TIME_W];
  assign rd_sent = rdata[TIME_W-1:0];
  assign lat_diff = time_now_r - rd_sent;

  psl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (cmd.send),
    .waddr(slot_r),
    .wdata({in_packet_id, time_now_r}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sts.hit      = pending_r[cmp_idx_r] && (rd_id == id_r);
  assign sts.last     = (cmp_idx_r == LAST_IDX);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r  <= '0;
      slot_r      <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick) begin
        time_now_r <= time_now_r + TIME_W'(1);
      end
      if (cmd.send) begin
        pending_r[slot_r] <= 1'b1;
        slot_r <= (slot_r == LAST_IDX) ? '0 : slot_r + IDXW'(1);
      end
      // free the matched entry
      if (cmd.capture && sts.hit) begin
        pending_r[cmp_idx_r] <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      id_r      <= in_packet_id;
      rd_idx_r  <= IDXW'(1);
      cmp_idx_r <= '0;
    end else if (cmd.step) begin
      cmp_idx_r <= cmp_idx_r + IDXW'(1);
      // hold at the final entry; reads past the search end are ignored
      if (rd_idx_r != LAST_IDX) begin
        rd_idx_r <= rd_idx_r + IDXW'(1);
      end
    end
    if (cmd.capture) begin
      res_found_r <= sts.hit;
      res_lat_r   <= sts.hit ? lat_diff : '0;
    end
    if (cmd.load_out) begin
      out_found_r <= res_found_r;
      out_lat_r   <= res_lat_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_latency = out_lat_r;

endmodule

FILE: src/psl_ctrl.sv
// Controller: decodes transactions and sequences the acknowledge search.
module psl_ctrl import psl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  psl_sts_t   sts,
  output psl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (func_t'(in_func))
            FUNC_TICK: cmd.tick = 1'b1;
            FUNC_SEND: cmd.send = 1'b1;
            FUNC_ACK: begin
              cmd.start = 1'b1;
              state_nxt = ST_SCAN;
            end
            default: ; // drop unused kind
          endcase
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.hit || sts.last) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
